FILE: rtl/transport_stream_packet_sync_top_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the transport stream packet sync block
// Clocked on clk, disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef TRANSPORT_STREAM_PACKET_SYNC_TOP_ASSERT_SVH
`define TRANSPORT_STREAM_PACKET_SYNC_TOP_ASSERT_SVH

// Same-cycle implication
`define TSPS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define TSPS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/tsps_pkg.sv
// ---------------------------------------------------------------------------
// tsps_pkg
// Types, codes and defaults shared by the packet sync block.
// ---------------------------------------------------------------------------
package tsps_pkg;

  // Default geometry
  localparam int PACKET_BYTES_DEF  = 188;
  localparam int PROBE_PACKETS_DEF = 4;

  // Fixed field widths
  localparam int OFFSET_W = 48;
  localparam int SKIP_W   = 8;
  localparam logic [SKIP_W-1:0] SKIP_MAX = 8'd255;

  // Sync byte register reset value
  localparam logic [7:0] SYNC_RESET = 8'd71;

  // Request codes
  localparam logic REQ_BYTE = 1'b0;
  localparam logic REQ_EOS  = 1'b1;

  // Event codes
  localparam logic EVT_PACKET = 1'b0;
  localparam logic EVT_FAIL   = 1'b1;

  // Input word
  typedef struct packed {
    logic       req_type;
    logic [7:0] byte_value;
  } in_word_t;

  // Result word
  typedef struct packed {
    logic                event_kind;
    logic [OFFSET_W-1:0] packet_offset;
    logic                last_of_run;
  } out_word_t;

  // Controller to datapath commands
  typedef struct packed {
    logic cnt_inc;
    logic cand_load;
    logic pkt_set1;
    logic pkt_inc;
    logic pkt_clr;
    logic skip_one;
    logic skip_drop;
    logic mark_wr;
    logic fill_clr;
    logic drop;
    logic scan_init;
    logic scan_inc;
    logic rd_chk;
    logic chk_init;
    logic chk_inc;
    logic emit_init;
    logic out_load;
    logic out_kind;
    logic out_last;
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic is_eos;
    logic is_sync;
    logic fill_zero;
    logic pkt_zero;
    logic pkt_end;
    logic check_hit;
    logic probe_full;
    logic skip1_fail;
    logic drop_fail;
    logic scan_end;
    logic rd_mark;
    logic chk_done;
    logic out_free;
  } dp_sts_t;

endpackage

FILE: rtl/tsps_datapath.sv
// ---------------------------------------------------------------------------
// tsps_datapath
// Counters, probe mark ring buffer, sync register and result register.
// ---------------------------------------------------------------------------
module tsps_datapath #(
  parameter int PACKET_BYTES  = tsps_pkg::PACKET_BYTES_DEF,
  parameter int PROBE_PACKETS = tsps_pkg::PROBE_PACKETS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  logic [7:0]          cfg_wr_data,
  input  tsps_pkg::in_word_t  in_word,
  input  tsps_pkg::dp_cmd_t   cmd,
  output tsps_pkg::dp_sts_t   sts,
  input  logic                out_stall,
  output logic                out_valid,
  output tsps_pkg::out_word_t out_word
);
  import tsps_pkg::*;

  localparam int DEPTH  = PACKET_BYTES * PROBE_PACKETS;
  localparam int FILL_W = $clog2(DEPTH + 1);
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int SUM_W  = FILL_W + 1;
  localparam int PKT_W  = $clog2(PACKET_BYTES);
  localparam int CHK_W  = $clog2(PROBE_PACKETS + 1);

  // Ring address: base plus index, folded once into the buffer depth
  function automatic logic [ADDR_W-1:0] ring_addr(input logic [ADDR_W-1:0] base,
                                                  input logic [FILL_W-1:0] idx);
    logic [FILL_W:0] sum;
    sum = {{(FILL_W + 1 - ADDR_W){1'b0}}, base} + {1'b0, idx};
    if (sum >= (FILL_W + 1)'(DEPTH)) begin
      sum = sum - (FILL_W + 1)'(DEPTH);
    end
    return sum[ADDR_W-1:0];
  endfunction

  logic [7:0]          sync_value_r, sync_value_nxt;
  logic [OFFSET_W-1:0] stream_cnt_r, stream_cnt_nxt;
  logic [OFFSET_W-1:0] cand_r, cand_nxt;
  logic [FILL_W-1:0]   fill_r, fill_nxt;
  logic [ADDR_W-1:0]   head_r, head_nxt;
  logic [SKIP_W-1:0]   skip_r, skip_nxt;
  logic [PKT_W-1:0]    pkt_r, pkt_nxt;
  logic [FILL_W-1:0]   scan_j_r, scan_j_nxt;
  logic [FILL_W-1:0]   chk_pos_r, chk_pos_nxt;
  logic [CHK_W-1:0]    chk_k_r, chk_k_nxt;
  logic [OFFSET_W-1:0] emit_off_r, emit_off_nxt;
  logic                out_valid_r, out_valid_nxt;
  out_word_t           out_word_r, out_word_nxt;

  logic                mark_mem [DEPTH];
  logic                rd_mark_r;
  logic [ADDR_W-1:0]   wr_addr;
  logic [ADDR_W-1:0]   rd_addr;
  logic                is_sync;
  logic                check_hit;
  logic [SUM_W-1:0]    skip_sum;
  logic [SUM_W-1:0]    drop_sum;
  logic [SKIP_W:0]     skip1_sum;

  assign is_sync   = in_word.byte_value == sync_value_r;
  assign wr_addr   = ring_addr(head_r, fill_r);
  assign rd_addr   = ring_addr(head_r, cmd.rd_chk ? chk_pos_r : scan_j_r);
  assign drop_sum  = SUM_W'(skip_r) + SUM_W'(scan_j_r);
  assign skip1_sum = {1'b0, skip_r} + (SKIP_W + 1)'(1);

  // New byte lands on a later packet start of the probe
  always_comb begin
    check_hit = 1'b0;
    for (int k = 1; k < PROBE_PACKETS; k++) begin
      check_hit = check_hit | (fill_r == FILL_W'(k * PACKET_BYTES));
    end
  end

  // Status toward the controller
  always_comb begin
    sts.is_eos     = in_word.req_type == REQ_EOS;
    sts.is_sync    = is_sync;
    sts.fill_zero  = fill_r == '0;
    sts.pkt_zero   = pkt_r == '0;
    sts.pkt_end    = ({1'b0, pkt_r} + (PKT_W + 1)'(1)) >= (PKT_W + 1)'(PACKET_BYTES);
    sts.check_hit  = check_hit;
    sts.probe_full = fill_r == FILL_W'(DEPTH - 1);
    sts.skip1_fail = skip1_sum >= (SKIP_W + 1)'(PACKET_BYTES);
    sts.drop_fail  = drop_sum >= SUM_W'(PACKET_BYTES);
    sts.scan_end   = scan_j_r == fill_r;
    sts.rd_mark    = rd_mark_r;
    sts.chk_done   = (chk_k_r == CHK_W'(PROBE_PACKETS)) || (chk_pos_r >= fill_r);
    sts.out_free   = !out_valid_r || !out_stall;
  end

  // Next-state logic
  always_comb begin
    sync_value_nxt = sync_value_r;
    stream_cnt_nxt = stream_cnt_r;
    cand_nxt       = cand_r;
    fill_nxt       = fill_r;
    head_nxt       = head_r;
    skip_nxt       = skip_r;
    pkt_nxt        = pkt_r;
    scan_j_nxt     = scan_j_r;
    chk_pos_nxt    = chk_pos_r;
    chk_k_nxt      = chk_k_r;
    emit_off_nxt   = emit_off_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_word_nxt   = out_word_r;
    skip_sum       = SUM_W'(skip_r);

    if (cfg_wr_en) begin
      sync_value_nxt = cfg_wr_data;
    end

    // Stream position and candidate start
    if (cmd.cnt_inc) begin
      stream_cnt_nxt = stream_cnt_r + OFFSET_W'(1);
    end
    if (cmd.cand_load) begin
      cand_nxt = stream_cnt_r;
    end else if (cmd.drop) begin
      cand_nxt = cand_r + OFFSET_W'(scan_j_r);
    end

    // Probe fill and ring head
    if (cmd.fill_clr) begin
      fill_nxt = '0;
    end else if (cmd.mark_wr) begin
      fill_nxt = fill_r + FILL_W'(1);
    end else if (cmd.drop) begin
      fill_nxt = fill_r - scan_j_r;
    end
    if (cmd.drop) begin
      head_nxt = ring_addr(head_r, scan_j_r);
    end

    // Skip count, saturating
    if (cmd.skip_one) begin
      skip_sum = SUM_W'(skip1_sum);
    end else if (cmd.skip_drop) begin
      skip_sum = drop_sum;
    end
    if (cmd.skip_one || cmd.skip_drop) begin
      skip_nxt = (skip_sum > SUM_W'(SKIP_MAX)) ? SKIP_MAX : skip_sum[SKIP_W-1:0];
    end

    // Synced packet fill
    if (cmd.pkt_clr) begin
      pkt_nxt = '0;
    end else if (cmd.pkt_set1) begin
      pkt_nxt = PKT_W'(1);
    end else if (cmd.pkt_inc) begin
      pkt_nxt = pkt_r + PKT_W'(1);
    end

    // Rescan index and check position
    if (cmd.scan_init) begin
      scan_j_nxt = FILL_W'(1);
    end else if (cmd.scan_inc) begin
      scan_j_nxt = scan_j_r + FILL_W'(1);
    end
    if (cmd.chk_init) begin
      chk_k_nxt   = CHK_W'(1);
      chk_pos_nxt = FILL_W'(PACKET_BYTES);
    end else if (cmd.chk_inc) begin
      chk_k_nxt   = chk_k_r + CHK_W'(1);
      chk_pos_nxt = chk_pos_r + FILL_W'(PACKET_BYTES);
    end

    // Result offsets and output register
    if (cmd.emit_init) begin
      emit_off_nxt = cand_r;
    end else if (cmd.out_load) begin
      emit_off_nxt = emit_off_r + OFFSET_W'(PACKET_BYTES);
    end
    if (cmd.out_load) begin
      out_valid_nxt              = 1'b1;
      out_word_nxt.event_kind    = cmd.out_kind;
      out_word_nxt.packet_offset = (cmd.out_kind == EVT_FAIL) ? '0 : emit_off_r;
      out_word_nxt.last_of_run   = cmd.out_last;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_value_r <= SYNC_RESET;
      stream_cnt_r <= '0;
      cand_r       <= '0;
      fill_r       <= '0;
      head_r       <= '0;
      skip_r       <= '0;
      pkt_r        <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      sync_value_r <= sync_value_nxt;
      stream_cnt_r <= stream_cnt_nxt;
      cand_r       <= cand_nxt;
      fill_r       <= fill_nxt;
      head_r       <= head_nxt;
      skip_r       <= skip_nxt;
      pkt_r        <= pkt_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    scan_j_r   <= scan_j_nxt;
    chk_pos_r  <= chk_pos_nxt;
    chk_k_r    <= chk_k_nxt;
    emit_off_r <= emit_off_nxt;
    out_word_r <= out_word_nxt;
  end

  // Probe mark memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.mark_wr) begin
      mark_mem[wr_addr] <= is_sync;
    end
    rd_mark_r <= mark_mem[rd_addr];
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

FILE: rtl/tsps_ctrl.sv
// ---------------------------------------------------------------------------
// tsps_ctrl
// Sync mode tracking and sequencer for byte steps, rescans and result runs.
// ---------------------------------------------------------------------------
module tsps_ctrl #(
  parameter int PROBE_PACKETS = tsps_pkg::PROBE_PACKETS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  tsps_pkg::dp_sts_t sts,
  output tsps_pkg::dp_cmd_t cmd
);
  import tsps_pkg::*;

  localparam int EMIT_W = $clog2(PROBE_PACKETS);

  typedef enum logic [5:0] {
    ST_IDLE    = 6'b000001,
    ST_SCAN_RD = 6'b000010,
    ST_SCAN_EV = 6'b000100,
    ST_CHK_RD  = 6'b001000,
    ST_CHK_EV  = 6'b010000,
    ST_EMIT    = 6'b100000
  } state_t;

  typedef enum logic [1:0] {
    MODE_INITIAL = 2'b00,
    MODE_SEEKING = 2'b01,
    MODE_SYNCED  = 2'b10
  } mode_t;

  state_t            state_r, state_nxt;
  mode_t             mode_r, mode_nxt;
  logic              failed_r, failed_nxt;
  logic              emit_fail_r, emit_fail_nxt;
  logic              emit_multi_r, emit_multi_nxt;
  logic [EMIT_W-1:0] emit_k_r, emit_k_nxt;
  logic              initial_mode;
  logic              emit_last;

  assign initial_mode = mode_r == MODE_INITIAL;
  assign emit_last    = !emit_multi_r || (emit_k_r == EMIT_W'(PROBE_PACKETS - 1));
  assign in_stall     = state_r != ST_IDLE;

  always_comb begin
    state_nxt      = state_r;
    mode_nxt       = mode_r;
    failed_nxt     = failed_r;
    emit_fail_nxt  = emit_fail_r;
    emit_multi_nxt = emit_multi_r;
    emit_k_nxt     = emit_k_r;
    cmd            = '0;

    case (state_r)
      // Take one word and run its step
      ST_IDLE: begin
        cmd.emit_init = 1'b1;
        emit_k_nxt    = '0;
        if (in_valid && !failed_r) begin
          if (sts.is_eos) begin
            if (initial_mode) begin
              failed_nxt     = 1'b1;
              emit_fail_nxt  = 1'b1;
              emit_multi_nxt = 1'b0;
              state_nxt      = ST_EMIT;
            end
          end else begin
            cmd.cnt_inc = 1'b1;
            case (mode_r)
              MODE_SYNCED: begin
                if (sts.pkt_zero) begin
                  if (!sts.is_sync) begin
                    mode_nxt = MODE_SEEKING;
                  end else begin
                    cmd.cand_load = 1'b1;
                    cmd.pkt_set1  = 1'b1;
                  end
                end else if (sts.pkt_end) begin
                  cmd.pkt_clr    = 1'b1;
                  emit_fail_nxt  = 1'b0;
                  emit_multi_nxt = 1'b0;
                  state_nxt      = ST_EMIT;
                end else begin
                  cmd.pkt_inc = 1'b1;
                end
              end
              default: begin
                if (sts.fill_zero && !sts.is_sync) begin
                  // Byte ahead of any candidate is skipped
                  if (initial_mode) begin
                    cmd.skip_one = 1'b1;
                    if (sts.skip1_fail) begin
                      failed_nxt     = 1'b1;
                      emit_fail_nxt  = 1'b1;
                      emit_multi_nxt = 1'b0;
                      state_nxt      = ST_EMIT;
                    end
                  end
                end else begin
                  cmd.cand_load = sts.fill_zero;
                  cmd.mark_wr   = 1'b1;
                  if (sts.check_hit && !sts.is_sync) begin
                    cmd.scan_init = 1'b1;
                    state_nxt     = ST_SCAN_RD;
                  end else if (sts.probe_full) begin
                    cmd.fill_clr   = 1'b1;
                    cmd.pkt_clr    = 1'b1;
                    mode_nxt       = MODE_SYNCED;
                    emit_fail_nxt  = 1'b0;
                    emit_multi_nxt = 1'b1;
                    state_nxt      = ST_EMIT;
                  end
                end
              end
            endcase
          end
        end
      end

      // Look for the next buffered sync mark
      ST_SCAN_RD: begin
        if (sts.scan_end) begin
          cmd.drop      = 1'b1;
          cmd.skip_drop = initial_mode;
          if (initial_mode && sts.drop_fail) begin
            failed_nxt     = 1'b1;
            emit_fail_nxt  = 1'b1;
            emit_multi_nxt = 1'b0;
            state_nxt      = ST_EMIT;
          end else begin
            state_nxt = ST_IDLE;
          end
        end else begin
          state_nxt = ST_SCAN_EV;
        end
      end

      ST_SCAN_EV: begin
        if (sts.rd_mark) begin
          cmd.drop      = 1'b1;
          cmd.skip_drop = initial_mode;
          if (initial_mode && sts.drop_fail) begin
            failed_nxt     = 1'b1;
            emit_fail_nxt  = 1'b1;
            emit_multi_nxt = 1'b0;
            state_nxt      = ST_EMIT;
          end else begin
            cmd.chk_init = 1'b1;
            state_nxt    = ST_CHK_RD;
          end
        end else begin
          cmd.scan_inc = 1'b1;
          state_nxt    = ST_SCAN_RD;
        end
      end

      // Verify later packet starts of the new candidate
      ST_CHK_RD: begin
        cmd.rd_chk = 1'b1;
        if (sts.chk_done) begin
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_CHK_EV;
        end
      end

      ST_CHK_EV: begin
        if (!sts.rd_mark) begin
          cmd.scan_init = 1'b1;
          state_nxt     = ST_SCAN_RD;
        end else begin
          cmd.chk_inc = 1'b1;
          state_nxt   = ST_CHK_RD;
        end
      end

      // Hand results to the output register
      ST_EMIT: begin
        cmd.out_kind = emit_fail_r ? EVT_FAIL : EVT_PACKET;
        cmd.out_last = emit_last;
        cmd.out_load = sts.out_free;
        if (sts.out_free) begin
          if (emit_last) begin
            state_nxt = ST_IDLE;
          end else begin
            emit_k_nxt = emit_k_r + EMIT_W'(1);
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      mode_r       <= MODE_INITIAL;
      failed_r     <= 1'b0;
      emit_fail_r  <= 1'b0;
      emit_multi_r <= 1'b0;
      emit_k_r     <= '0;
    end else begin
      state_r      <= state_nxt;
      mode_r       <= mode_nxt;
      failed_r     <= failed_nxt;
      emit_fail_r  <= emit_fail_nxt;
      emit_multi_r <= emit_multi_nxt;
      emit_k_r     <= emit_k_nxt;
    end
  end

endmodule

FILE: rtl/transport_stream_packet_sync_top.sv
// ---------------------------------------------------------------------------
// transport_stream_packet_sync_top
// Finds packet alignment in a transport stream byte stream and reports the
// start offset of each framed packet, or a single initial sync failure.
//
//   channel  direction  handshake            word
//   in_      input      in_valid / in_stall   req_type, byte_value
//   out_     output     out_valid / out_stall event_kind, packet_offset, last
//   cfg_     input      cfg_wr_en             sync_value
//
// Input words are taken only in the idle state. A word that completes a
// packet yields one result and a confirming word PROBE_PACKETS results.
// A failed probe check rescans the mark memory through its single read port:
// a read and an evaluate state per scanned byte and per verified packet start.
// Synchronous reset; no memory clearing pass, marks are only read below fill.
// in_stall is high outside the idle state; out_stall holds the result run.
// ---------------------------------------------------------------------------
`include "transport_stream_packet_sync_top_assert.svh"

module transport_stream_packet_sync_top #(
  parameter int PACKET_BYTES  = tsps_pkg::PACKET_BYTES_DEF,
  parameter int PROBE_PACKETS = tsps_pkg::PROBE_PACKETS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  logic [7:0]          cfg_wr_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  tsps_pkg::in_word_t  in_word,
  output logic                out_valid,
  input  logic                out_stall,
  output tsps_pkg::out_word_t out_word
);
  import tsps_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  // Sequencer
  tsps_ctrl #(
    .PROBE_PACKETS(PROBE_PACKETS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Counters, mark memory and result register
  tsps_datapath #(
    .PACKET_BYTES (PACKET_BYTES),
    .PROBE_PACKETS(PROBE_PACKETS)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_word    (in_word),
    .cmd        (cmd),
    .sts        (sts),
    .out_stall  (out_stall),
    .out_valid  (out_valid),
    .out_word   (out_word)
  );

  // Results load only into a free output register
  `TSPS_ASSERT_IMPL(a_load_free, cmd.out_load, sts.out_free, "result loaded over a held word")

  // No result is loaded while input words are taken
  `TSPS_ASSERT_IMPL(a_load_busy, cmd.out_load, in_stall, "result loaded in idle state")

  // A sync failure is always a single-result run
  `TSPS_ASSERT_NEXT(a_fail_last, cmd.out_load && (cmd.out_kind == EVT_FAIL),
                    out_valid && out_word.last_of_run, "sync failure not last of run")

endmodule
